// File: rtl/restoring_unsigned_divider_defines.svh
// Assertion macros used by the divider top level
`ifndef RESTORING_UNSIGNED_DIVIDER_DEFINES_SVH
`define RESTORING_UNSIGNED_DIVIDER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define RUD_ASSERT_IMPL(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define RUD_ASSERT_NEXT(lbl, ck, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/rud_pkg.sv
// Shared types for the restoring divider cell chain
`timescale 1ns / 1ps

package rud_pkg;

	// Control that travels with a beat from cell to cell
	typedef struct packed {
		logic valid;
		logic err;
	} rud_ctl_t;

endpackage

// File: rtl/rud_cell.sv
// One restoring division step with its own stage register
`timescale 1ns / 1ps

module rud_cell
	import rud_pkg::*;
#(
	parameter int DATA_WIDTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rud_ctl_t              up_ctl,
	input  logic [DATA_WIDTH-1:0] up_rem,
	input  logic [DATA_WIDTH-1:0] up_aq,
	input  logic [DATA_WIDTH-1:0] up_div,
	output logic                  stall,
	input  logic                  dn_stall,
	output rud_ctl_t              ctl_q,
	output logic [DATA_WIDTH-1:0] rem_q,
	output logic [DATA_WIDTH-1:0] aq_q,
	output logic [DATA_WIDTH-1:0] div_q
);

	logic                  advance;
	logic                  valid_q;
	logic                  err_q;
	logic [DATA_WIDTH:0]   trial;
	logic [DATA_WIDTH:0]   diff;
	logic                  fits;
	logic [DATA_WIDTH-1:0] rem_n;
	logic [DATA_WIDTH-1:0] aq_n;

	// Move on when this stage is empty or the next one takes the beat
	assign advance = !valid_q || !dn_stall;
	assign stall   = !advance;
	assign ctl_q   = '{valid: valid_q, err: err_q};

	// Shift in the next dividend bit and subtract the divisor if it fits
	always_comb begin
		trial = {up_rem, up_aq[DATA_WIDTH-1]};
		diff  = trial - {1'b0, up_div};
		fits  = (trial >= {1'b0, up_div});
		rem_n = fits ? diff[DATA_WIDTH-1:0] : trial[DATA_WIDTH-1:0];
		aq_n  = {up_aq[DATA_WIDTH-2:0], fits};
	end

	// Clear the valid bit under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (advance) begin
			valid_q <= up_ctl.valid;
		end
	end

	// Load the payload only with a real beat
	always_ff @(posedge clk) begin
		if (advance && up_ctl.valid) begin
			err_q <= up_ctl.err;
			rem_q <= rem_n;
			aq_q  <= aq_n;
			div_q <= up_div;
		end
	end

endmodule

// File: rtl/restoring_unsigned_divider.sv
// An accepted beat passes through the DATA_WIDTH cell registers to the rsp side.
// Throughput: one beat per cycle while rsp_stall is low; one quotient bit per cell.
// Stalls ripple back cell by cell, so empty cells close up behind a held result.
// Reset clears every cell's valid bit at once; no payload is cleared.
`timescale 1ns / 1ps
`include "restoring_unsigned_divider_defines.svh"

module restoring_unsigned_divider
	import rud_pkg::*;
#(
	parameter int DATA_WIDTH = 8
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  req_valid,
	output logic                  req_stall,
	input  logic [DATA_WIDTH-1:0] dividend,
	input  logic [DATA_WIDTH-1:0] divisor,
	output logic                  rsp_valid,
	input  logic                  rsp_stall,
	output logic [DATA_WIDTH-1:0] quotient,
	output logic [DATA_WIDTH-1:0] remainder,
	output logic                  error_code
);

	rud_ctl_t              ctl_a   [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] rem_a   [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] aq_a    [0:DATA_WIDTH];
	logic [DATA_WIDTH-1:0] div_a   [0:DATA_WIDTH];
	logic                  stall_a [0:DATA_WIDTH];

	// Feed the head of the chain from the request beat
	assign ctl_a[0]       = '{valid: req_valid, err: (divisor == '0)};
	assign rem_a[0]       = '0;
	assign aq_a[0]        = dividend;
	assign div_a[0]       = divisor;
	assign req_stall      = stall_a[0];
	assign stall_a[DATA_WIDTH] = rsp_stall;

	// Chain of division cells, one quotient bit each
	for (genvar i = 0; i < DATA_WIDTH; i++) begin : g_cell
		rud_cell #(
			.DATA_WIDTH (DATA_WIDTH)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.up_ctl   (ctl_a[i]),
			.up_rem   (rem_a[i]),
			.up_aq    (aq_a[i]),
			.up_div   (div_a[i]),
			.stall    (stall_a[i]),
			.dn_stall (stall_a[i+1]),
			.ctl_q    (ctl_a[i+1]),
			.rem_q    (rem_a[i+1]),
			.aq_q     (aq_a[i+1]),
			.div_q    (div_a[i+1])
		);
	end

	// Drive the result, forcing zeros for a zero divisor
	assign rsp_valid  = ctl_a[DATA_WIDTH].valid;
	assign error_code = ctl_a[DATA_WIDTH].err;
	assign quotient   = ctl_a[DATA_WIDTH].err ? '0 : aq_a[DATA_WIDTH];
	assign remainder  = ctl_a[DATA_WIDTH].err ? '0 : rem_a[DATA_WIDTH];

	`RUD_ASSERT_IMPL(a_empty_tail_ready, clk, arst_n, !rsp_valid, !req_stall, "request stalled with empty tail")
	`RUD_ASSERT_IMPL(a_rem_below_div, clk, arst_n, rsp_valid && !error_code, remainder < div_a[DATA_WIDTH], "remainder not below divisor")
	`RUD_ASSERT_NEXT(a_accept_lands, clk, arst_n, req_valid && !req_stall, ctl_a[1].valid, "accepted beat lost at first cell")

endmodule
